>>> hdl/cau_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// cau_pkg
// Shared types, command codes and saturation helpers for the complex ALU.
// ----------------------------------------------------------------------------
package cau_pkg;

  localparam int DATA_W = 32;
  localparam int TOL_W  = 31;
  localparam logic [TOL_W-1:0] TOL_RESET = TOL_W'(7);

  typedef enum logic [2:0] {
    CMD_ADD   = 3'd0,
    CMD_SUB   = 3'd1,
    CMD_MUL   = 3'd2,
    CMD_CDIV  = 3'd3,
    CMD_SDIV  = 3'd4,
    CMD_CONJ  = 3'd5,
    CMD_MODSQ = 3'd6,
    CMD_EQ    = 3'd7
  } cmd_t;

  typedef struct packed {
    cmd_t                     cmd;
    logic signed [DATA_W-1:0] a_re;
    logic signed [DATA_W-1:0] a_im;
    logic signed [DATA_W-1:0] b_re;
    logic signed [DATA_W-1:0] b_im;
  } in_t;

  typedef struct packed {
    logic signed [DATA_W-1:0] res_re;
    logic signed [DATA_W-1:0] res_im;
    logic                     is_equal;
    logic                     div_by_zero;
    logic                     overflowed;
  } out_t;

  localparam logic [2*DATA_W:0] POS_MAX = (2*DATA_W+1)'({1'b0, {(DATA_W-1){1'b1}}});
  localparam logic [2*DATA_W:0] NEG_MAX = (2*DATA_W+1)'({1'b1, {(DATA_W-1){1'b0}}});

  // {overflow, value} from sign and magnitude
  function automatic logic [DATA_W:0] sat_mag(input logic neg, input logic [2*DATA_W:0] m);
    logic [DATA_W:0] res;
    if (neg) begin
      if (m > NEG_MAX) res = {1'b1, 1'b1, {(DATA_W-1){1'b0}}};
      else             res = {1'b0, DATA_W'(0) - m[DATA_W-1:0]};
    end else begin
      if (m > POS_MAX) res = {1'b1, 1'b0, {(DATA_W-1){1'b1}}};
      else             res = {1'b0, m[DATA_W-1:0]};
    end
    return res;
  endfunction

  // {overflow, value} from a signed sum one bit wider than the result
  function automatic logic [DATA_W:0] sat_sum(input logic signed [DATA_W:0] s);
    logic [DATA_W:0] res;
    if (s[DATA_W] != s[DATA_W-1]) res = {1'b1, s[DATA_W], {(DATA_W-1){~s[DATA_W]}}};
    else                          res = {1'b0, s[DATA_W-1:0]};
    return res;
  endfunction

endpackage

>>> hdl/cau_div.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// cau_div
// Pipelined restoring divider, one quotient bit per stage. big flags a
// quotient that does not fit in QW bits.
// ----------------------------------------------------------------------------
module cau_div #(
  parameter int NW = 80,
  parameter int DW = 64,
  parameter int QW = 32
) (
  input  logic          clk,
  input  logic          en,
  input  logic [NW-1:0] num,
  input  logic [DW-1:0] den,
  output logic [QW-1:0] q,
  output logic          big
);

  logic [DW-1:0] r_r   [0:QW];
  logic [QW-1:0] lo_r  [0:QW];
  logic [DW-1:0] d_r   [0:QW];
  logic [QW-1:0] q_r   [0:QW];
  logic          big_r [0:QW];

  logic [DW-1:0] hi;
  logic [DW:0]   t     [1:QW];
  logic          ge    [1:QW];

  assign hi = DW'(num[NW-1:QW]);

  always_comb begin
    for (int k = 1; k <= QW; k++) begin
      t[k]  = {r_r[k-1], lo_r[k-1][QW-1]};
      ge[k] = t[k] >= {1'b0, d_r[k-1]};
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      r_r[0]   <= hi;
      lo_r[0]  <= num[QW-1:0];
      d_r[0]   <= den;
      q_r[0]   <= '0;
      big_r[0] <= hi >= den;
      for (int k = 1; k <= QW; k++) begin
        r_r[k]   <= ge[k] ? DW'(t[k] - {1'b0, d_r[k-1]}) : t[k][DW-1:0];
        lo_r[k]  <= lo_r[k-1] << 1;
        d_r[k]   <= d_r[k-1];
        q_r[k]   <= {q_r[k-1][QW-2:0], ge[k]};
        big_r[k] <= big_r[k-1];
      end
    end
  end

  assign q   = q_r[QW];
  assign big = big_r[QW];

endmodule

>>> hdl/complex_arith_unit.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// complex_arith_unit
// Complex ALU on signed Q16.16 operands: add, sub, mul, divides, conj,
// squared modulus and equality within a tolerance.
// ----------------------------------------------------------------------------
// Fully pipelined: one item accepted per cycle unless stalled; the result passes
// two multiply/sum stages, one stage per quotient bit of the 32-bit divider
// plus its setup stage, and the output register. The whole pipe stalls only
// while the output register holds a result not taken; bubbles stay in place.
module complex_arith_unit #(
  parameter int FRAC_BITS = 16
) (
  input  logic                     clk,
  input  logic                     rst_n,
  input  logic                     in_valid,
  output logic                     in_ready,
  input  cau_pkg::in_t             in_data,
  output logic                     out_valid,
  input  logic                     out_ready,
  output cau_pkg::out_t            out_data,
  input  logic                     cfg_we,
  input  logic [cau_pkg::TOL_W-1:0] cfg_wdata
);

  localparam int W  = cau_pkg::DATA_W;
  localparam int PW = 2 * W;
  localparam int SW = PW + 1;
  localparam int NW = PW + FRAC_BITS;
  localparam int MW = 2 * W + 1;

  typedef struct packed {
    cau_pkg::cmd_t        cmd;
    logic signed [W-1:0]  re;
    logic signed [W-1:0]  im;
    logic                 eq;
    logic                 ov;
    logic                 dz;
    logic                 neg_re;
    logic                 neg_im;
  } side_t;

  logic en;
  logic [cau_pkg::TOL_W-1:0] tol_r;

  // stage 1
  logic                 v1_r;
  cau_pkg::in_t         d1_r;
  logic signed [PW-1:0] p_arbr_r, p_aibi_r, p_aibr_r, p_arbi_r;
  logic signed [PW-1:0] p_arar_r, p_aiai_r, p_brbr_r, p_bibi_r;
  side_t                s1_r, s1_nxt;

  // stage 2
  logic                 v2_r;
  cau_pkg::in_t         d2_r;
  logic signed [SW-1:0] mulr_r, muli_r, divr_r, divi_r;
  logic [PW-1:0]        modsq_r, den_r;
  side_t                s2_r;

  // divider feed
  side_t                s3;
  logic [NW-1:0]        num_re, num_im;
  logic [PW-1:0]        den;
  logic [PW-1:0]        m_mulr, m_muli, m_divr, m_divi;
  logic [W:0]           sr_mulr, sr_muli, sr_mod;

  logic                 vd_r   [0:W];
  side_t                side_r [0:W];
  logic [W-1:0]         q_re, q_im;
  logic                 big_re, big_im;

  logic                 out_valid_r;
  cau_pkg::out_t        out_r, out_nxt;

  assign en       = !out_valid_r || out_ready;
  assign in_ready = en;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      tol_r <= cau_pkg::TOL_RESET;
    end else if (cfg_we) begin
      tol_r <= cfg_wdata;
    end
  end

  // simple ops in stage 1
  always_comb begin
    logic signed [W:0] s_re, s_im, d_re, d_im;
    logic [W:0]        m_re, m_im;
    logic [W:0]        t_re, t_im;
    s_re = {in_data.a_re[W-1], in_data.a_re};
    s_im = {in_data.a_im[W-1], in_data.a_im};
    d_re = s_re - {in_data.b_re[W-1], in_data.b_re};
    d_im = s_im - {in_data.b_im[W-1], in_data.b_im};
    m_re = d_re[W] ? (W+1)'(0) - d_re : d_re;
    m_im = d_im[W] ? (W+1)'(0) - d_im : d_im;
    s1_nxt     = '0;
    s1_nxt.cmd = in_data.cmd;
    unique case (in_data.cmd)
      cau_pkg::CMD_ADD: begin
        t_re = cau_pkg::sat_sum(s_re + {in_data.b_re[W-1], in_data.b_re});
        t_im = cau_pkg::sat_sum(s_im + {in_data.b_im[W-1], in_data.b_im});
      end
      cau_pkg::CMD_SUB: begin
        t_re = cau_pkg::sat_sum(d_re);
        t_im = cau_pkg::sat_sum(d_im);
      end
      cau_pkg::CMD_CONJ: begin
        t_re = {1'b0, in_data.a_re};
        t_im = cau_pkg::sat_sum((W+1)'(0) - s_im);
      end
      default: begin
        t_re = '0;
        t_im = '0;
      end
    endcase
    s1_nxt.re  = t_re[W-1:0];
    s1_nxt.im  = t_im[W-1:0];
    s1_nxt.ov  = t_re[W] | t_im[W];
    s1_nxt.eq  = (in_data.cmd == cau_pkg::CMD_EQ) &&
                 (m_re <= (W+1)'(tol_r)) && (m_im <= (W+1)'(tol_r));
    s1_nxt.dz  = (in_data.cmd == cau_pkg::CMD_CDIV) ?
                 (in_data.b_re == '0 && in_data.b_im == '0) : (in_data.b_re == '0);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v1_r <= 1'b0;
      v2_r <= 1'b0;
    end else if (en) begin
      v1_r <= in_valid;
      v2_r <= v1_r;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      d1_r     <= in_data;
      s1_r     <= s1_nxt;
      p_arbr_r <= in_data.a_re * in_data.b_re;
      p_aibi_r <= in_data.a_im * in_data.b_im;
      p_aibr_r <= in_data.a_im * in_data.b_re;
      p_arbi_r <= in_data.a_re * in_data.b_im;
      p_arar_r <= in_data.a_re * in_data.a_re;
      p_aiai_r <= in_data.a_im * in_data.a_im;
      p_brbr_r <= in_data.b_re * in_data.b_re;
      p_bibi_r <= in_data.b_im * in_data.b_im;

      d2_r    <= d1_r;
      s2_r    <= s1_r;
      mulr_r  <= SW'(p_arbr_r) - SW'(p_aibi_r);
      muli_r  <= SW'(p_aibr_r) + SW'(p_arbi_r);
      divr_r  <= SW'(p_arbr_r) + SW'(p_aibi_r);
      divi_r  <= SW'(p_aibr_r) - SW'(p_arbi_r);
      modsq_r <= PW'(p_arar_r) + PW'(p_aiai_r);
      den_r   <= PW'(p_brbr_r) + PW'(p_bibi_r);
    end
  end

  // stage 3: magnitudes, mul/modsq saturation, divider operands
  always_comb begin
    logic [W-1:0] mag_ar, mag_ai, mag_br;
    m_mulr = PW'(mulr_r[SW-1] ? SW'(0) - mulr_r : mulr_r);
    m_muli = PW'(muli_r[SW-1] ? SW'(0) - muli_r : muli_r);
    m_divr = PW'(divr_r[SW-1] ? SW'(0) - divr_r : divr_r);
    m_divi = PW'(divi_r[SW-1] ? SW'(0) - divi_r : divi_r);
    sr_mulr = cau_pkg::sat_mag(mulr_r[SW-1], MW'(m_mulr >> FRAC_BITS));
    sr_muli = cau_pkg::sat_mag(muli_r[SW-1], MW'(m_muli >> FRAC_BITS));
    sr_mod  = cau_pkg::sat_mag(1'b0, MW'(modsq_r >> FRAC_BITS));
    mag_ar = d2_r.a_re[W-1] ? W'(0) - d2_r.a_re : d2_r.a_re;
    mag_ai = d2_r.a_im[W-1] ? W'(0) - d2_r.a_im : d2_r.a_im;
    mag_br = d2_r.b_re[W-1] ? W'(0) - d2_r.b_re : d2_r.b_re;

    s3 = s2_r;
    if (s2_r.cmd == cau_pkg::CMD_SDIV) begin
      num_re    = NW'(mag_ar) << FRAC_BITS;
      num_im    = NW'(mag_ai) << FRAC_BITS;
      den       = PW'(mag_br);
      s3.neg_re = d2_r.a_re[W-1] != d2_r.b_re[W-1];
      s3.neg_im = d2_r.a_im[W-1] != d2_r.b_re[W-1];
    end else begin
      num_re    = NW'(m_divr) << FRAC_BITS;
      num_im    = NW'(m_divi) << FRAC_BITS;
      den       = den_r;
      s3.neg_re = divr_r[SW-1];
      s3.neg_im = divi_r[SW-1];
    end
    if (s2_r.cmd == cau_pkg::CMD_MUL) begin
      s3.re = sr_mulr[W-1:0];
      s3.im = sr_muli[W-1:0];
      s3.ov = sr_mulr[W] | sr_muli[W];
    end else if (s2_r.cmd == cau_pkg::CMD_MODSQ) begin
      s3.re = sr_mod[W-1:0];
      s3.im = '0;
      s3.ov = sr_mod[W];
    end
  end

  cau_div #(.NW(NW), .DW(PW), .QW(W)) u_div_re (
    .clk(clk), .en(en), .num(num_re), .den(den), .q(q_re), .big(big_re)
  );

  cau_div #(.NW(NW), .DW(PW), .QW(W)) u_div_im (
    .clk(clk), .en(en), .num(num_im), .den(den), .q(q_im), .big(big_im)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int k = 0; k <= W; k++) vd_r[k] <= 1'b0;
    end else if (en) begin
      vd_r[0] <= v2_r;
      for (int k = 1; k <= W; k++) vd_r[k] <= vd_r[k-1];
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      side_r[0] <= s3;
      for (int k = 1; k <= W; k++) side_r[k] <= side_r[k-1];
    end
  end

  // output stage
  always_comb begin
    side_t      sd;
    logic [W:0] qr, qi;
    sd = side_r[W];
    qr = cau_pkg::sat_mag(sd.neg_re, big_re ? cau_pkg::POS_MAX << 2 : MW'(q_re));
    qi = cau_pkg::sat_mag(sd.neg_im, big_im ? cau_pkg::POS_MAX << 2 : MW'(q_im));
    out_nxt.is_equal    = sd.eq;
    out_nxt.div_by_zero = 1'b0;
    out_nxt.res_re      = sd.re;
    out_nxt.res_im      = sd.im;
    out_nxt.overflowed  = sd.ov;
    if (sd.cmd == cau_pkg::CMD_CDIV || sd.cmd == cau_pkg::CMD_SDIV) begin
      if (sd.dz) begin
        out_nxt.div_by_zero = 1'b1;
        out_nxt.res_re      = '0;
        out_nxt.res_im      = '0;
        out_nxt.overflowed  = 1'b0;
      end else begin
        out_nxt.res_re      = qr[W-1:0];
        out_nxt.res_im      = qi[W-1:0];
        out_nxt.overflowed  = qr[W] | qi[W];
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (en) begin
      out_valid_r <= vd_r[W];
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      out_r <= out_nxt;
    end
  end

  assign out_valid = out_valid_r;
  assign out_data  = out_r;

endmodule

>>> hdl/cau_checker.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// cau_checker
// Port-level checks for complex_arith_unit, bound to the top level.
// ----------------------------------------------------------------------------
module cau_checker (
  input logic          clk,
  input logic          rst_n,
  input logic          in_ready,
  input logic          out_valid,
  input logic          out_ready,
  input cau_pkg::out_t out_data
);

  a_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid && $stable(out_data))
    else $error("result item changed while stalled");

  a_ready: assert property (@(posedge clk) disable iff (!rst_n)
    in_ready == (!out_valid || out_ready))
    else $error("input ready does not follow output stage");

  a_reset: assert property (@(posedge clk)
    !rst_n |=> !out_valid)
    else $error("result valid after reset");

  a_dz: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_data.div_by_zero |->
      out_data.res_re == '0 && out_data.res_im == '0 && !out_data.overflowed
      && !out_data.is_equal)
    else $error("divide by zero item with nonzero result");

  a_eq: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_data.is_equal |->
      out_data.res_re == '0 && out_data.res_im == '0 && !out_data.overflowed)
    else $error("equal item with nonzero result");

endmodule

bind complex_arith_unit cau_checker u_cau_checker (
  .clk(clk),
  .rst_n(rst_n),
  .in_ready(in_ready),
  .out_valid(out_valid),
  .out_ready(out_ready),
  .out_data(out_data)
);

>>> tb/tb_top.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_top
// Self-checking bench for complex_arith_unit: directed corner items and
// random operand mixes for every command, over several equality tolerances,
// with random idling on both channels; results are compared with a predictor.
// ----------------------------------------------------------------------------
module tb_top;

  localparam int LATENCY   = 40;
  localparam int MAX_CYCLE = 400000;
  localparam logic signed [31:0] SMAX = 32'sh7fffffff;
  localparam logic signed [31:0] SMIN = 32'sh80000000;

  class cau_scoreboard;
    localparam int FRAC = 16;

    cau_pkg::out_t             pending_q[$];
    logic [cau_pkg::TOL_W-1:0] tol;
    int                        errors;

    function new();
      tol    = cau_pkg::TOL_RESET;
      errors = 0;
    endfunction

    static function logic [31:0] clip(input logic signed [127:0] v, inout logic ov);
      if (v > 128'sd2147483647) begin
        ov = 1'b1;
        return SMAX;
      end
      if (v < -128'sd2147483648) begin
        ov = 1'b1;
        return SMIN;
      end
      return v[31:0];
    endfunction

    static function logic [31:0] clip_mag(input logic neg, input logic [127:0] m,
                                          inout logic ov);
      if (neg) begin
        if (m > 128'h80000000) begin
          ov = 1'b1;
          return SMIN;
        end
        return 32'd0 - m[31:0];
      end
      if (m > 128'h7fffffff) begin
        ov = 1'b1;
        return SMAX;
      end
      return m[31:0];
    endfunction

    static function logic [127:0] absv(input logic signed [127:0] v);
      return (v < 0) ? -v : v;
    endfunction

    function cau_pkg::out_t compute(input cau_pkg::in_t x);
      logic signed [127:0] ar, ai, br, bi, s;
      logic [127:0] den;
      logic ov;
      cau_pkg::out_t r;
      ar = x.a_re;
      ai = x.a_im;
      br = x.b_re;
      bi = x.b_im;
      r  = '0;
      ov = 1'b0;
      case (x.cmd)
        cau_pkg::CMD_ADD: begin
          r.res_re = clip(ar + br, ov);
          r.res_im = clip(ai + bi, ov);
        end
        cau_pkg::CMD_SUB: begin
          r.res_re = clip(ar - br, ov);
          r.res_im = clip(ai - bi, ov);
        end
        cau_pkg::CMD_MUL: begin
          s = ar * br - ai * bi;
          r.res_re = clip_mag(s < 0, absv(s) >> FRAC, ov);
          s = ai * br + ar * bi;
          r.res_im = clip_mag(s < 0, absv(s) >> FRAC, ov);
        end
        cau_pkg::CMD_CDIV: begin
          den = br * br + bi * bi;
          if (den == 0) r.div_by_zero = 1'b1;
          else begin
            s = ar * br + ai * bi;
            r.res_re = clip_mag(s < 0, (absv(s) << FRAC) / den, ov);
            s = ai * br - ar * bi;
            r.res_im = clip_mag(s < 0, (absv(s) << FRAC) / den, ov);
          end
        end
        cau_pkg::CMD_SDIV: begin
          if (br == 0) r.div_by_zero = 1'b1;
          else begin
            r.res_re = clip_mag((ar < 0) != (br < 0), (absv(ar) << FRAC) / absv(br), ov);
            r.res_im = clip_mag((ai < 0) != (br < 0), (absv(ai) << FRAC) / absv(br), ov);
          end
        end
        cau_pkg::CMD_CONJ: begin
          r.res_re = x.a_re;
          r.res_im = clip(-ai, ov);
        end
        cau_pkg::CMD_MODSQ: r.res_re = clip_mag(1'b0, (ar * ar + ai * ai) >> FRAC, ov);
        default:   r.is_equal = (absv(ar - br) <= tol) && (absv(ai - bi) <= tol);
      endcase
      r.overflowed = ov;
      return r;
    endfunction

    function void note_item(input cau_pkg::in_t x);
      pending_q.push_back(compute(x));
    endfunction

    function void check_result(input cau_pkg::out_t got);
      cau_pkg::out_t exp_r;
      if (pending_q.size() == 0) begin
        $display("%0t: unexpected result %h", $time, got);
        errors++;
        return;
      end
      exp_r = pending_q.pop_front();
      if (got.res_re !== exp_r.res_re) begin
        $display("%0t: res_re exp %h got %h", $time, exp_r.res_re, got.res_re);
        errors++;
      end
      if (got.res_im !== exp_r.res_im) begin
        $display("%0t: res_im exp %h got %h", $time, exp_r.res_im, got.res_im);
        errors++;
      end
      if (got.is_equal !== exp_r.is_equal) begin
        $display("%0t: is_equal exp %b got %b", $time, exp_r.is_equal, got.is_equal);
        errors++;
      end
      if (got.div_by_zero !== exp_r.div_by_zero) begin
        $display("%0t: div_by_zero exp %b got %b", $time, exp_r.div_by_zero,
                 got.div_by_zero);
        errors++;
      end
      if (got.overflowed !== exp_r.overflowed) begin
        $display("%0t: overflowed exp %b got %b", $time, exp_r.overflowed, got.overflowed);
        errors++;
      end
    endfunction
  endclass

  logic                      clk;
  logic                      rst_n;
  logic                      in_valid;
  logic                      in_ready;
  cau_pkg::in_t              in_data;
  logic                      out_valid;
  logic                      out_ready;
  cau_pkg::out_t             out_data;
  logic                      cfg_we;
  logic [cau_pkg::TOL_W-1:0] cfg_wdata;

  cau_scoreboard sb;
  logic          calm;
  int            cycles;

  complex_arith_unit DUT (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .in_ready (in_ready),
    .in_data  (in_data),
    .out_valid(out_valid),
    .out_ready(out_ready),
    .out_data (out_data),
    .cfg_we   (cfg_we),
    .cfg_wdata(cfg_wdata)
  );

  initial begin
    clk = 1'b0;
    forever #1 clk = ~clk;
  end

  initial begin
    rst_n     = 1'b0;
    in_valid  = 1'b0;
    in_data   = '0;
    out_ready = 1'b0;
    cfg_we    = 1'b0;
    cfg_wdata = '0;
    calm      = 1'b0;
    cycles    = 0;
    sb        = new();
  end

  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles > MAX_CYCLE) begin
      $display("CHECK FAILED");
      $finish;
    end
  end

  always @(negedge clk)
    if (rst_n) out_ready <= calm ? 1'b1 : ($urandom_range(99) >= 32);

  always @(posedge clk)
    if (rst_n && out_valid && out_ready) sb.check_result(out_data);

  task automatic send_item(input cau_pkg::in_t x);
    int gap;
    if (!calm && $urandom_range(99) < 32) begin
      gap = $urandom_range(4, 1);
      in_valid <= 1'b0;
      repeat (gap) @(negedge clk);
    end
    in_valid <= 1'b1;
    in_data  <= x;
    do @(posedge clk); while (!in_ready);
    sb.note_item(x);
    @(negedge clk);
  endtask

  task automatic drain();
    in_valid <= 1'b0;
    while (sb.pending_q.size() != 0) @(negedge clk);
    repeat (LATENCY) @(negedge clk);
  endtask

  task automatic write_tol(input logic [cau_pkg::TOL_W-1:0] v);
    cfg_we    <= 1'b1;
    cfg_wdata <= v;
    @(negedge clk);
    cfg_we <= 1'b0;
    sb.tol = v;
  endtask

  function automatic cau_pkg::in_t mk(input cau_pkg::cmd_t c, input logic [31:0] ar,
                                      input logic [31:0] ai, input logic [31:0] br,
                                      input logic [31:0] bi);
    cau_pkg::in_t x;
    x.cmd  = c;
    x.a_re = ar;
    x.a_im = ai;
    x.b_re = br;
    x.b_im = bi;
    return x;
  endfunction

  function automatic logic [31:0] pick_corner();
    case ($urandom_range(5))
      0: return SMAX;
      1: return SMIN;
      2: return 32'd0;
      3: return 32'd1;
      4: return 32'hffffffff;
      default: return 32'h00010000;
    endcase
  endfunction

  function automatic cau_pkg::in_t rand_item();
    cau_pkg::in_t x;
    int           mode;
    x    = mk(cau_pkg::cmd_t'($urandom_range(7)), $urandom, $urandom, $urandom, $urandom);
    mode = $urandom_range(9);
    if (mode >= 4 && mode <= 6) begin
      x.a_re = {{12{x.a_re[19]}}, x.a_re[19:0]};
      x.a_im = {{12{x.a_im[19]}}, x.a_im[19:0]};
      x.b_re = {{12{x.b_re[19]}}, x.b_re[19:0]};
      x.b_im = {{12{x.b_im[19]}}, x.b_im[19:0]};
    end else if (mode == 7) begin
      x.a_re = pick_corner();
      x.a_im = pick_corner();
      x.b_re = pick_corner();
      x.b_im = pick_corner();
    end else if (mode >= 8) begin
      x.b_re = x.a_re + $signed($urandom_range(32)) - 16;
      x.b_im = x.a_im + $signed($urandom_range(32)) - 16;
    end
    return x;
  endfunction

  initial begin
    logic [cau_pkg::TOL_W-1:0] tols[4];
    cau_pkg::in_t              dir_q[$];
    tols[0] = 31'd7;
    tols[1] = 31'd0;
    tols[2] = 31'h7fffffff;
    tols[3] = cau_pkg::TOL_W'($urandom_range(4000));

    dir_q.push_back(mk(cau_pkg::CMD_ADD, SMAX, SMIN, SMAX, SMIN));
    dir_q.push_back(mk(cau_pkg::CMD_ADD, 32'h00010000, 32'hffff0000, 32'h00008000, 32'd5));
    dir_q.push_back(mk(cau_pkg::CMD_SUB, SMIN, SMAX, SMAX, SMIN));
    dir_q.push_back(mk(cau_pkg::CMD_SUB, 32'd100, 32'd0, 32'd300, 32'd0));
    dir_q.push_back(mk(cau_pkg::CMD_MUL, SMIN, SMIN, SMIN, SMIN));
    dir_q.push_back(mk(cau_pkg::CMD_MUL, 32'h00018000, 32'hfffe8000, 32'h00020000,
                       32'h00000001));
    dir_q.push_back(mk(cau_pkg::CMD_MUL, 32'hffffffff, 32'd0, 32'd1, 32'd0));
    dir_q.push_back(mk(cau_pkg::CMD_CDIV, 32'h00030000, 32'h00010000, 32'd0, 32'd0));
    dir_q.push_back(mk(cau_pkg::CMD_CDIV, 32'h00030000, 32'hfffe0000, 32'h00010000,
                       32'h00020000));
    dir_q.push_back(mk(cau_pkg::CMD_CDIV, SMAX, SMIN, 32'd1, 32'd0));
    dir_q.push_back(mk(cau_pkg::CMD_CDIV, SMIN, SMAX, SMIN, SMAX));
    dir_q.push_back(mk(cau_pkg::CMD_SDIV, 32'h00050000, 32'h00070000, 32'd0, 32'h00010000));
    dir_q.push_back(mk(cau_pkg::CMD_SDIV, SMIN, SMAX, 32'hffffffff, 32'd0));
    dir_q.push_back(mk(cau_pkg::CMD_SDIV, 32'hfffb0000, 32'h00070000, 32'h00030000, SMIN));
    dir_q.push_back(mk(cau_pkg::CMD_SDIV, SMIN, 32'hffffffff, 32'h00010000, 32'd0));
    dir_q.push_back(mk(cau_pkg::CMD_CONJ, SMAX, SMIN, SMAX, SMAX));
    dir_q.push_back(mk(cau_pkg::CMD_CONJ, SMIN, SMAX, 32'd0, 32'd0));
    dir_q.push_back(mk(cau_pkg::CMD_MODSQ, SMIN, SMIN, 32'd3, 32'd4));
    dir_q.push_back(mk(cau_pkg::CMD_MODSQ, 32'h00030000, 32'hfffc0000, 32'd0, 32'd0));
    dir_q.push_back(mk(cau_pkg::CMD_EQ, 32'd100, 32'd200, 32'd107, 32'd193));
    dir_q.push_back(mk(cau_pkg::CMD_EQ, 32'd100, 32'd200, 32'd108, 32'd200));
    dir_q.push_back(mk(cau_pkg::CMD_EQ, SMIN, SMAX, SMAX, SMIN));
    dir_q.push_back(mk(cau_pkg::CMD_EQ, SMAX, SMIN, SMAX, SMIN));

    repeat (12) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;
    @(negedge clk);

    for (int ph = 0; ph < 4; ph++) begin
      drain();
      write_tol(tols[ph]);
      foreach (dir_q[i]) send_item(dir_q[i]);
      if (ph == 0) drain();
      for (int i = 0; i < 140; i++) begin
        calm = (ph == 2) && (i >= 20) && (i < 100);
        send_item(rand_item());
      end
      calm = 1'b0;
    end

    drain();
    if (sb.errors == 0) $display("CHECK OK");
    else $display("CHECK FAILED");
    $finish;
  end

endmodule

>>> filelist.f
hdl/cau_pkg.sv
hdl/cau_div.sv
hdl/complex_arith_unit.sv
hdl/cau_checker.sv
tb/tb_top.sv
